// ===== rtl/core/cfrx_pkg.sv =====
// ----------------------------------------------------------------------------
// cfrx_pkg
// Shared widths, codes and helpers for the checksum frame receiver.
// ----------------------------------------------------------------------------
package cfrx_pkg;

   // Default and field widths.
   localparam int MAX_FRAME_LEN_DEF = 32;
   localparam int BYTE_W            = 8;
   localparam int STATUS_W          = 2;
   localparam int KIND_W            = 4;
   localparam int CHECK_W           = 2;
   localparam int LEN_W             = 6;
   localparam int CSR_IDX_W         = 2;
   localparam int RSP_BITS          = STATUS_W + KIND_W + 3 * BYTE_W + CHECK_W + LEN_W;
   localparam int RSP_DATA_W        = ((RSP_BITS + 7) / 8) * 8;

   // Bit positions inside the result item's data word.
   localparam int STATUS_LSB = 0;
   localparam int KIND_LSB   = STATUS_LSB + STATUS_W;
   localparam int FUNC_LSB   = KIND_LSB + KIND_W;
   localparam int FIRST_LSB  = FUNC_LSB + BYTE_W;
   localparam int SECOND_LSB = FIRST_LSB + BYTE_W;
   localparam int CHECK_LSB  = SECOND_LSB + BYTE_W;
   localparam int LEN_LSB    = CHECK_LSB + CHECK_W;

   // Frame bytes.
   localparam logic [BYTE_W-1:0] HEADER_BYTE  = 8'hAA;
   localparam logic [BYTE_W-1:0] FN_STATUS    = 8'h01;
   localparam logic [BYTE_W-1:0] FN_SENSOR    = 8'h02;
   localparam logic [BYTE_W-1:0] FN_GPS       = 8'h04;
   localparam logic [BYTE_W-1:0] FN_POWER     = 8'h05;
   localparam logic [BYTE_W-1:0] FN_MESSAGE   = 8'hEE;
   localparam logic [BYTE_W-1:0] FN_GROUP1    = 8'h10;
   localparam logic [BYTE_W-1:0] FN_GROUP2    = 8'h11;
   localparam logic [BYTE_W-1:0] FN_GROUP3    = 8'h12;
   localparam logic [BYTE_W-1:0] FN_CHECK     = 8'hEF;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_SUM   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_HDR   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_TOO_SHORT = 2'd3;

   // Frame kinds.
   localparam logic [KIND_W-1:0] KIND_STATUS  = 4'd0;
   localparam logic [KIND_W-1:0] KIND_SENSOR  = 4'd1;
   localparam logic [KIND_W-1:0] KIND_GPS     = 4'd2;
   localparam logic [KIND_W-1:0] KIND_POWER   = 4'd3;
   localparam logic [KIND_W-1:0] KIND_MESSAGE = 4'd4;
   localparam logic [KIND_W-1:0] KIND_GROUP1  = 4'd5;
   localparam logic [KIND_W-1:0] KIND_GROUP2  = 4'd6;
   localparam logic [KIND_W-1:0] KIND_GROUP3  = 4'd7;
   localparam logic [KIND_W-1:0] KIND_CHECK   = 4'd8;
   localparam logic [KIND_W-1:0] KIND_UNKNOWN = 4'd9;

   // Group check results.
   localparam logic [CHECK_W-1:0] CHK_NONE     = 2'd0;
   localparam logic [CHECK_W-1:0] CHK_MATCH    = 2'd1;
   localparam logic [CHECK_W-1:0] CHK_MISMATCH = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_GROUP1_SUM = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GROUP2_SUM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GROUP3_SUM = 2'd2;

   // Maps a function byte to its frame kind.
   function automatic logic [KIND_W-1:0] classify(input logic [BYTE_W-1:0] fn);
      logic [KIND_W-1:0] kind;
      case (fn)
         FN_STATUS:  kind = KIND_STATUS;
         FN_SENSOR:  kind = KIND_SENSOR;
         FN_GPS:     kind = KIND_GPS;
         FN_POWER:   kind = KIND_POWER;
         FN_MESSAGE: kind = KIND_MESSAGE;
         FN_GROUP1:  kind = KIND_GROUP1;
         FN_GROUP2:  kind = KIND_GROUP2;
         FN_GROUP3:  kind = KIND_GROUP3;
         FN_CHECK:   kind = KIND_CHECK;
         default:    kind = KIND_UNKNOWN;
      endcase
      return kind;
   endfunction

endpackage

// ===== rtl/core/checksum_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// checksum_frame_receiver_core
// Parses received radio frames byte by byte and reports one checked result
// item per frame.
// ----------------------------------------------------------------------------
// The req_ channel carries one frame byte per item in req_tdata, with
// req_tlast high on the final byte, which is the frame's checksum. Bytes of a
// frame are counted, summed modulo 256 and the bytes at offsets 0, 1, 2, 4
// and 5 are kept. When the final byte is taken, one result item is produced
// on the rsp_ channel; all other bytes produce nothing.
// The result is computed in the cycle the final byte is accepted and held in
// the output register, so it shows on rsp_tvalid in the next cycle. The block
// takes one byte per cycle without gaps, including while a finished result is
// taken: req_tready drops only when the output register is full and the
// downstream side holds rsp_tready low, so a stall of the result channel
// pushes back on the byte stream after at most one pending result.
// The csr_ port writes the three expected group sums; it is meant to be used
// while no frame is in progress. Synchronous reset clears the frame state,
// the output valid flag and the expected sums.
// ----------------------------------------------------------------------------
module checksum_frame_receiver_core #(
   parameter int MAX_FRAME_LEN = cfrx_pkg::MAX_FRAME_LEN_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // Byte stream. req_tdata: [7:0] rx_byte. req_tlast: frame_end.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [cfrx_pkg::BYTE_W-1:0]      req_tdata,
   input  logic                             req_tlast,
   // Results. rsp_tdata, from bit 0 up: frame_status[1:0], frame_kind[5:2],
   // function_code[13:6], first_payload[21:14], second_payload[29:22],
   // check_result[31:30], frame_length[37:32], zero fill [39:38].
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [cfrx_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // Register writes.
   input  logic                             csr_we,
   input  logic [cfrx_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cfrx_pkg::BYTE_W-1:0]      csr_wdata
);

   localparam int CNT_W = $clog2(MAX_FRAME_LEN + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_LEN);

   // Expected sums of the three parameter groups.
   logic [cfrx_pkg::BYTE_W-1:0] group1_sum_ff, group2_sum_ff, group3_sum_ff;

   // Frame state, cleared after every final byte.
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [cfrx_pkg::BYTE_W-1:0] sum_ff, sum_in;
   logic [cfrx_pkg::BYTE_W-1:0] lead_ff, lead_in;
   logic [cfrx_pkg::BYTE_W-1:0] second_ff, second_in;
   logic [cfrx_pkg::BYTE_W-1:0] func_ff, func_in;
   logic [cfrx_pkg::BYTE_W-1:0] first_ff, first_in;
   logic [cfrx_pkg::BYTE_W-1:0] pay2_ff, pay2_in;

   // Output register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [cfrx_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                        req_fire;
   logic [cfrx_pkg::BYTE_W-1:0] rx_byte;

   // Offsets as they stand once the current byte is captured.
   logic [cfrx_pkg::BYTE_W-1:0] lead_cap, second_cap, func_cap, first_cap, pay2_cap;

   logic [CNT_W-1:0]              len;
   logic [CNT_W+cfrx_pkg::LEN_W-1:0] len_ext;
   logic [cfrx_pkg::STATUS_W-1:0] status;
   logic [cfrx_pkg::KIND_W-1:0]   kind;
   logic [cfrx_pkg::CHECK_W-1:0]  check;
   logic [cfrx_pkg::BYTE_W-1:0]   want_sum;
   logic                          group_known;

   assign rx_byte    = req_tdata;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign lead_cap   = (count_ff == CNT_W'(0)) ? rx_byte : lead_ff;
   assign second_cap = (count_ff == CNT_W'(1)) ? rx_byte : second_ff;
   assign func_cap   = (count_ff == CNT_W'(2)) ? rx_byte : func_ff;
   assign first_cap  = (count_ff == CNT_W'(4)) ? rx_byte : first_ff;
   assign pay2_cap   = (count_ff == CNT_W'(5)) ? rx_byte : pay2_ff;

   // Length including the final byte, held at the maximum.
   assign len     = (count_ff == CNT_MAX) ? CNT_MAX : count_ff + CNT_W'(1);
   assign len_ext = {{cfrx_pkg::LEN_W{1'b0}}, len};

   // Checks in order: too short, checksum, header; then classification.
   always_comb begin
      if (count_ff < CNT_W'(2)) begin
         status = cfrx_pkg::ST_TOO_SHORT;
      end else if (sum_ff != rx_byte) begin
         status = cfrx_pkg::ST_BAD_SUM;
      end else if (lead_cap != cfrx_pkg::HEADER_BYTE || second_cap != cfrx_pkg::HEADER_BYTE) begin
         status = cfrx_pkg::ST_BAD_HDR;
      end else begin
         status = cfrx_pkg::ST_OK;
      end

      group_known = 1'b1;
      case (first_cap)
         cfrx_pkg::FN_GROUP1: want_sum = group1_sum_ff;
         cfrx_pkg::FN_GROUP2: want_sum = group2_sum_ff;
         cfrx_pkg::FN_GROUP3: want_sum = group3_sum_ff;
         default: begin
            want_sum    = '0;
            group_known = 1'b0;
         end
      endcase

      kind  = cfrx_pkg::KIND_UNKNOWN;
      check = cfrx_pkg::CHK_NONE;
      if (status == cfrx_pkg::ST_OK) begin
         kind = cfrx_pkg::classify(func_cap);
         if (kind == cfrx_pkg::KIND_CHECK && group_known) begin
            check = (want_sum == pay2_cap) ? cfrx_pkg::CHK_MATCH : cfrx_pkg::CHK_MISMATCH;
         end
      end
   end

   // Frame state update for an accepted byte.
   always_comb begin
      count_in  = count_ff;
      sum_in    = sum_ff;
      lead_in   = lead_ff;
      second_in = second_ff;
      func_in   = func_ff;
      first_in  = first_ff;
      pay2_in   = pay2_ff;
      if (req_fire) begin
         if (req_tlast) begin
            count_in  = '0;
            sum_in    = '0;
            lead_in   = '0;
            second_in = '0;
            func_in   = '0;
            first_in  = '0;
            pay2_in   = '0;
         end else begin
            sum_in    = sum_ff + rx_byte;
            count_in  = (count_ff == CNT_MAX) ? CNT_MAX : count_ff + CNT_W'(1);
            lead_in   = lead_cap;
            second_in = second_cap;
            func_in   = func_cap;
            first_in  = first_cap;
            pay2_in   = pay2_cap;
         end
      end
   end

   // Output register: loads on a final byte, empties when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (req_fire && req_tlast) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_data_in[cfrx_pkg::STATUS_LSB +: cfrx_pkg::STATUS_W] = status;
         rsp_data_in[cfrx_pkg::KIND_LSB   +: cfrx_pkg::KIND_W]   = kind;
         rsp_data_in[cfrx_pkg::FUNC_LSB   +: cfrx_pkg::BYTE_W]   = func_cap;
         rsp_data_in[cfrx_pkg::FIRST_LSB  +: cfrx_pkg::BYTE_W]   = first_cap;
         rsp_data_in[cfrx_pkg::SECOND_LSB +: cfrx_pkg::BYTE_W]   = pay2_cap;
         rsp_data_in[cfrx_pkg::CHECK_LSB  +: cfrx_pkg::CHECK_W]  = check;
         rsp_data_in[cfrx_pkg::LEN_LSB    +: cfrx_pkg::LEN_W]    =
            len_ext[cfrx_pkg::LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         sum_ff        <= '0;
         lead_ff       <= '0;
         second_ff     <= '0;
         func_ff       <= '0;
         first_ff      <= '0;
         pay2_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         group1_sum_ff <= '0;
         group2_sum_ff <= '0;
         group3_sum_ff <= '0;
      end else begin
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         lead_ff      <= lead_in;
         second_ff    <= second_in;
         func_ff      <= func_in;
         first_ff     <= first_in;
         pay2_ff      <= pay2_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               cfrx_pkg::REG_GROUP1_SUM: group1_sum_ff <= csr_wdata;
               cfrx_pkg::REG_GROUP2_SUM: group2_sum_ff <= csr_wdata;
               cfrx_pkg::REG_GROUP3_SUM: group3_sum_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/core/cfrx_checker.sv =====
// ----------------------------------------------------------------------------
// cfrx_checker
// Port-level checks on the checksum frame receiver, bound into its core module.
// ----------------------------------------------------------------------------
module cfrx_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tlast,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [cfrx_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic                          req_fire;
   logic [cfrx_pkg::STATUS_W-1:0] st;
   logic [cfrx_pkg::KIND_W-1:0]   kd;
   logic [cfrx_pkg::CHECK_W-1:0]  ck;

   assign req_fire = req_tvalid && req_tready;
   assign st = rsp_tdata[cfrx_pkg::STATUS_LSB +: cfrx_pkg::STATUS_W];
   assign kd = rsp_tdata[cfrx_pkg::KIND_LSB +: cfrx_pkg::KIND_W];
   assign ck = rsp_tdata[cfrx_pkg::CHECK_LSB +: cfrx_pkg::CHECK_W];

   // A result that is not taken stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed or vanished while stalled");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // A final byte always yields a result on the next cycle.
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tlast |=> rsp_tvalid)
      else $error("final byte produced no result");

   // A byte inside a frame yields nothing once the output side is free.
   a_mid_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_tlast && (!rsp_tvalid || rsp_tready) |=> !rsp_tvalid)
      else $error("result without a final byte");

   // A failed frame is never classified or group-checked.
   a_fail_unknown: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st != cfrx_pkg::ST_OK |->
         kd == cfrx_pkg::KIND_UNKNOWN && ck == cfrx_pkg::CHK_NONE)
      else $error("failed frame carries a kind or check result");

endmodule

bind checksum_frame_receiver_core cfrx_checker u_cfrx_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== test/frame_report_checker.sv =====
// ----------------------------------------------------------------------------
// frame_report_checker
// Watches the byte stream, the result stream and the register writes of the
// checksum frame receiver, predicts one report per frame and compares it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module frame_report_checker #(
   parameter int FRAME_LEN_CAP = cfrx_pkg::MAX_FRAME_LEN_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [cfrx_pkg::BYTE_W-1:0]     req_tdata,
   input  logic                            req_tlast,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [cfrx_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic [cfrx_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cfrx_pkg::BYTE_W-1:0]     csr_wdata,
   output int                              fail_count,
   output int                              outstanding
);

   typedef struct packed {
      logic [cfrx_pkg::STATUS_W-1:0] status;
      logic [cfrx_pkg::KIND_W-1:0]   kind;
      logic [cfrx_pkg::BYTE_W-1:0]   func;
      logic [cfrx_pkg::BYTE_W-1:0]   first;
      logic [cfrx_pkg::BYTE_W-1:0]   second;
      logic [cfrx_pkg::CHECK_W-1:0]  check;
      logic [cfrx_pkg::LEN_W-1:0]    len;
   } frame_report_type;

   frame_report_type            pending_reports[$];
   logic [cfrx_pkg::BYTE_W-1:0] group_sum[3];

   // Frame being assembled.
   int                          frame_count;
   logic [cfrx_pkg::BYTE_W-1:0] frame_sum;
   logic [cfrx_pkg::BYTE_W-1:0] lead_byte;
   logic [cfrx_pkg::BYTE_W-1:0] second_byte;
   logic [cfrx_pkg::BYTE_W-1:0] func_byte;
   logic [cfrx_pkg::BYTE_W-1:0] first_payload;
   logic [cfrx_pkg::BYTE_W-1:0] second_payload;

   task automatic clear_frame();
      frame_count    = 0;
      frame_sum      = '0;
      lead_byte      = '0;
      second_byte    = '0;
      func_byte      = '0;
      first_payload  = '0;
      second_payload = '0;
   endtask

   task automatic compare_field(input string name,
                                input logic [cfrx_pkg::BYTE_W-1:0] want,
                                input logic [cfrx_pkg::BYTE_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Takes one accepted byte; on the final byte of a frame a report is queued.
   task automatic absorb_byte(input logic [cfrx_pkg::BYTE_W-1:0] b, input logic last);
      frame_report_type rep;
      int               len;
      case (frame_count)
         0: lead_byte = b;
         1: second_byte = b;
         2: func_byte = b;
         4: first_payload = b;
         5: second_payload = b;
         default: ;
      endcase
      if (!last) begin
         frame_sum = frame_sum + b;
         if (frame_count < FRAME_LEN_CAP) frame_count++;
      end else begin
         len = frame_count + 1;
         if (len > FRAME_LEN_CAP) len = FRAME_LEN_CAP;
         if (len < 3) rep.status = cfrx_pkg::ST_TOO_SHORT;
         else if (frame_sum != b) rep.status = cfrx_pkg::ST_BAD_SUM;
         else if (lead_byte != cfrx_pkg::HEADER_BYTE || second_byte != cfrx_pkg::HEADER_BYTE)
            rep.status = cfrx_pkg::ST_BAD_HDR;
         else rep.status = cfrx_pkg::ST_OK;
         rep.kind  = cfrx_pkg::KIND_UNKNOWN;
         rep.check = cfrx_pkg::CHK_NONE;
         if (rep.status == cfrx_pkg::ST_OK) begin
            case (func_byte)
               cfrx_pkg::FN_STATUS:  rep.kind = cfrx_pkg::KIND_STATUS;
               cfrx_pkg::FN_SENSOR:  rep.kind = cfrx_pkg::KIND_SENSOR;
               cfrx_pkg::FN_GPS:     rep.kind = cfrx_pkg::KIND_GPS;
               cfrx_pkg::FN_POWER:   rep.kind = cfrx_pkg::KIND_POWER;
               cfrx_pkg::FN_MESSAGE: rep.kind = cfrx_pkg::KIND_MESSAGE;
               cfrx_pkg::FN_GROUP1:  rep.kind = cfrx_pkg::KIND_GROUP1;
               cfrx_pkg::FN_GROUP2:  rep.kind = cfrx_pkg::KIND_GROUP2;
               cfrx_pkg::FN_GROUP3:  rep.kind = cfrx_pkg::KIND_GROUP3;
               cfrx_pkg::FN_CHECK:   rep.kind = cfrx_pkg::KIND_CHECK;
               default:              rep.kind = cfrx_pkg::KIND_UNKNOWN;
            endcase
            if (rep.kind == cfrx_pkg::KIND_CHECK) begin
               case (first_payload)
                  cfrx_pkg::FN_GROUP1:
                     rep.check = (group_sum[0] == second_payload) ? cfrx_pkg::CHK_MATCH
                                                                  : cfrx_pkg::CHK_MISMATCH;
                  cfrx_pkg::FN_GROUP2:
                     rep.check = (group_sum[1] == second_payload) ? cfrx_pkg::CHK_MATCH
                                                                  : cfrx_pkg::CHK_MISMATCH;
                  cfrx_pkg::FN_GROUP3:
                     rep.check = (group_sum[2] == second_payload) ? cfrx_pkg::CHK_MATCH
                                                                  : cfrx_pkg::CHK_MISMATCH;
                  default: rep.check = cfrx_pkg::CHK_NONE;
               endcase
            end
         end
         rep.func   = func_byte;
         rep.first  = first_payload;
         rep.second = second_payload;
         rep.len    = len[cfrx_pkg::LEN_W-1:0];
         pending_reports.push_back(rep);
         clear_frame();
      end
   endtask

   always @(posedge clock) begin
      frame_report_type want;
      frame_report_type got;
      if (reset) begin
         pending_reports.delete();
         group_sum   = '{default: '0};
         fail_count  = 0;
         clear_frame();
         outstanding <= 0;
      end else begin
         // Results are compared before this edge's byte is predicted, so a
         // stray result is never matched against a report made at the same edge.
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[cfrx_pkg::STATUS_LSB +: cfrx_pkg::STATUS_W];
            got.kind   = rsp_tdata[cfrx_pkg::KIND_LSB +: cfrx_pkg::KIND_W];
            got.func   = rsp_tdata[cfrx_pkg::FUNC_LSB +: cfrx_pkg::BYTE_W];
            got.first  = rsp_tdata[cfrx_pkg::FIRST_LSB +: cfrx_pkg::BYTE_W];
            got.second = rsp_tdata[cfrx_pkg::SECOND_LSB +: cfrx_pkg::BYTE_W];
            got.check  = rsp_tdata[cfrx_pkg::CHECK_LSB +: cfrx_pkg::CHECK_W];
            got.len    = rsp_tdata[cfrx_pkg::LEN_LSB +: cfrx_pkg::LEN_W];
            if (pending_reports.size() == 0) begin
               $display("%0t: result expected none, actual %h", $time, rsp_tdata);
               fail_count++;
            end else begin
               want = pending_reports.pop_front();
               compare_field("frame_status", want.status, got.status);
               compare_field("frame_kind", want.kind, got.kind);
               compare_field("function_code", want.func, got.func);
               compare_field("first_payload", want.first, got.first);
               compare_field("second_payload", want.second, got.second);
               compare_field("check_result", want.check, got.check);
               compare_field("frame_length", want.len, got.len);
            end
         end
         if (csr_we) begin
            case (csr_index)
               cfrx_pkg::REG_GROUP1_SUM: group_sum[0] = csr_wdata;
               cfrx_pkg::REG_GROUP2_SUM: group_sum[1] = csr_wdata;
               cfrx_pkg::REG_GROUP3_SUM: group_sum[2] = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) absorb_byte(req_tdata, req_tlast);
         outstanding <= pending_reports.size();
      end
   end

endmodule

// ===== test/tb_checksum_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// tb_checksum_frame_receiver_core
// Feeds frames of bytes into the receiver and checks one report per frame.
// ----------------------------------------------------------------------------
// A short directed run covers the shortest frames, a minimal good frame, a
// group check against the reset sums, an unknown group and a frame that fails
// both the checksum and the header. Four random phases follow, each with its
// own set of expected group sums and its own pattern of sender gaps and result
// stalls. Most random frames are well formed, with random function, payload
// and length; the rest carry a bad checksum, a bad header, too few bytes or
// plain noise. The checker beside the block predicts and compares; this
// module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_checksum_frame_receiver_core;

   localparam int FRAME_LEN_CAP  = cfrx_pkg::MAX_FRAME_LEN_DEF;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS    = 380;
   localparam int BYTE_W         = cfrx_pkg::BYTE_W;
   // The fourth register index has no register behind it.
   localparam logic [cfrx_pkg::CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [BYTE_W-1:0]               req_tdata;     // [7:0] rx_byte
   logic                            req_tlast;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [cfrx_pkg::RSP_DATA_W-1:0] rsp_tdata;     // status, kind, function, payloads,
                                                   // check result, length, zero fill
   logic                            csr_we;
   logic [cfrx_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [BYTE_W-1:0]               csr_wdata;

   int fail_count;
   int outstanding;
   int item_count;
   int send_idle_pct;
   int rsp_stall_pct;
   int quiet_cycles;

   // Our own copy of the expected sums, used only to aim check frames at a
   // match about half of the time.
   logic [BYTE_W-1:0] group_sum[3];

   checksum_frame_receiver_core #(.MAX_FRAME_LEN(FRAME_LEN_CAP)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   frame_report_checker #(.FRAME_LEN_CAP(FRAME_LEN_CAP)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // The result side stalls at random with the current phase's rate.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // The watchdog counts cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("checksum_frame_receiver_core: mismatch");
            $finish;
         end
      end
   end

   // Sends one byte. Gaps are taken before the byte, so valid is never
   // lowered and raised at the same edge.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      item_count++;
   endtask

   // Sends the body followed by its checksum byte; a nonzero offset spoils
   // the checksum on purpose.
   task automatic send_frame(input logic [BYTE_W-1:0] body[$],
                             input logic [BYTE_W-1:0] sum_offset);
      logic [BYTE_W-1:0] sum;
      sum = '0;
      foreach (body[i]) begin
         sum = sum + body[i];
         send_byte(body[i], 1'b0);
      end
      send_byte(sum + sum_offset, 1'b1);
   endtask

   task automatic send_random_frame();
      logic [BYTE_W-1:0] body[$];
      logic [BYTE_W-1:0] fn;
      logic [BYTE_W-1:0] sum_offset;
      int                roll;
      int                total;
      int                pick;
      int                grp;
      roll       = $urandom_range(99);
      sum_offset = '0;
      // Mostly short frames; now and then a longer one that may run past the length cap.
      if ($urandom_range(9) == 0) total = $urandom_range(11, 40);
      else total = $urandom_range(3, 10);
      if (roll >= 94) begin
         total      = $urandom_range(1, 40);
         sum_offset = BYTE_W'($urandom_range(255));
      end else if (roll >= 88) begin
         total      = $urandom_range(1, 2);
         sum_offset = BYTE_W'($urandom_range(255));
      end
      for (int i = 0; i < total - 1; i++) body.push_back(BYTE_W'($urandom_range(255)));
      if (roll < 88) begin
         body[0] = cfrx_pkg::HEADER_BYTE;
         body[1] = cfrx_pkg::HEADER_BYTE;
         pick = $urandom_range(11);
         case (pick)
            0: fn = cfrx_pkg::FN_STATUS;
            1: fn = cfrx_pkg::FN_SENSOR;
            2: fn = cfrx_pkg::FN_GPS;
            3: fn = cfrx_pkg::FN_POWER;
            4: fn = cfrx_pkg::FN_MESSAGE;
            5: fn = cfrx_pkg::FN_GROUP1;
            6: fn = cfrx_pkg::FN_GROUP2;
            7: fn = cfrx_pkg::FN_GROUP3;
            11: fn = BYTE_W'($urandom_range(255));
            default: fn = cfrx_pkg::FN_CHECK;
         endcase
         if (body.size() > 2) body[2] = fn;
         if (fn == cfrx_pkg::FN_CHECK && body.size() > 4) begin
            grp = $urandom_range(2);
            // Mostly a known group, sometimes a stray group byte.
            if ($urandom_range(4) != 0) body[4] = BYTE_W'(cfrx_pkg::FN_GROUP1 + grp);
            if (body.size() > 5 && $urandom_range(1) == 1) body[5] = group_sum[grp];
         end
         if (roll >= 80) begin
            // Bad header: one or both leading bytes are not the header byte.
            pick = $urandom_range(2);
            if (pick != 1)
               body[0] = cfrx_pkg::HEADER_BYTE ^ BYTE_W'($urandom_range(1, 255));
            if (pick != 0)
               body[1] = cfrx_pkg::HEADER_BYTE ^ BYTE_W'($urandom_range(1, 255));
         end else if (roll >= 70) begin
            sum_offset = BYTE_W'($urandom_range(1, 255));
         end
      end
      send_frame(body, sum_offset);
   endtask

   // Every frame has ended when this is called, so the block is idle once
   // the last report is out and its output register has drained.
   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Writes all three sums and a value to the unused index, which must not
   // disturb any of them.
   task automatic program_sums(input logic [BYTE_W-1:0] s1, input logic [BYTE_W-1:0] s2,
                               input logic [BYTE_W-1:0] s3);
      group_sum[0] = s1;
      group_sum[1] = s2;
      group_sum[2] = s3;
      csr_we    <= 1'b1;
      csr_index <= cfrx_pkg::REG_GROUP1_SUM;
      csr_wdata <= s1;
      @(posedge clock);
      csr_index <= cfrx_pkg::REG_GROUP2_SUM;
      csr_wdata <= s2;
      @(posedge clock);
      csr_index <= REG_UNUSED;
      csr_wdata <= BYTE_W'($urandom_range(255));
      @(posedge clock);
      csr_index <= cfrx_pkg::REG_GROUP3_SUM;
      csr_wdata <= s3;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [BYTE_W-1:0] body[$];
      int                phase_start;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tlast     = 1'b0;
      csr_we        = 1'b0;
      csr_index     = cfrx_pkg::REG_GROUP1_SUM;
      csr_wdata     = '0;
      item_count    = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      group_sum     = '{default: '0};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames, with the expected sums still at their reset value.
      body = '{};
      send_frame(body, 8'hFF);                  // one byte: too short
      body = '{cfrx_pkg::HEADER_BYTE};
      send_frame(body, 8'h00);                  // two bytes: too short
      body = '{cfrx_pkg::HEADER_BYTE, cfrx_pkg::HEADER_BYTE};
      send_frame(body, 8'h00);                  // checksum lands on the function
      body = '{cfrx_pkg::HEADER_BYTE, cfrx_pkg::HEADER_BYTE, cfrx_pkg::FN_CHECK, 8'h00,
               cfrx_pkg::FN_GROUP1, 8'h00};
      send_frame(body, 8'h00);                  // group check that matches
      body = '{cfrx_pkg::HEADER_BYTE, cfrx_pkg::HEADER_BYTE, cfrx_pkg::FN_CHECK, 8'hFF,
               8'h13, 8'hFF};
      send_frame(body, 8'h00);                  // group byte names no group
      body = '{8'h00, 8'hFF, cfrx_pkg::FN_STATUS};
      send_frame(body, 8'h80);                  // bad checksum wins over bad header
      wait_for_idle();

      // Random phases: no idling, slow sender, slow receiver, light idling
      // on both sides.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: program_sums(8'hFF, 8'hFF, 8'hFF);
            1: program_sums(8'h00, 8'hFF, BYTE_W'($urandom_range(255)));
            default: program_sums(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                                  BYTE_W'($urandom_range(255)));
         endcase
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 88;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 88;
            end
            default: begin
               send_idle_pct = 9;
               rsp_stall_pct = 9;
            end
         endcase
         phase_start = item_count;
         while (item_count - phase_start < PHASE_ITEMS) send_random_frame();
         wait_for_idle();
      end

      if (fail_count == 0) begin
         $display("checksum_frame_receiver_core: match");
      end else begin
         $display("checksum_frame_receiver_core: mismatch");
      end
      $finish;
   end

endmodule
